@@ rtl/core/crba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crba_pkg
// Shared types, codes and reset values for the chained region bump allocator.
// ----------------------------------------------------------------------------
package crba_pkg;

  localparam int unsigned CRBA_MAX_REGIONS = 16;
  localparam int unsigned CRBA_MISS_LIMIT  = 4;

  localparam int unsigned SIZE_W   = 17;
  localparam int unsigned HDR_W    = 8;
  localparam int unsigned MISS_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] REGION_BYTES_RST = 17'd4096;
  localparam logic [HDR_W-1:0]  FIRST_HDR_RST    = 8'd40;
  localparam logic [HDR_W-1:0]  LATER_HDR_RST    = 8'd32;
  localparam logic [MISS_W-1:0] MISS_MAX         = 3'd7;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 2'd0,
    ST_NO_REGION = 2'd1,
    ST_TOO_BIG   = 2'd2,
    ST_RELEASED  = 2'd3
  } crba_status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_REGION_BYTES = 2'd0,
    REG_FIRST_HDR    = 2'd1,
    REG_LATER_HDR    = 2'd2
  } crba_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_NEW,
    S_MISS_RD,
    S_MISS_WR,
    S_OPEN,
    S_RESP
  } crba_state_e;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] request_size;
  } crba_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    region_index;
    logic [SIZE_W-1:0]   byte_offset;
  } crba_rsp_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;
  } crba_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic release_all;
    logic rd_fill;
    logic check;
    logic new_eval;
    logic miss_rd;
    logic miss_wr;
    logic open_region;
    logic load_out;
  } crba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fit;
    logic scan_more;
    logic too_big;
    logic chain_full;
    logic cur_has_next;
    logic miss_more;
  } crba_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/crba_chan_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crba_chan_if
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
interface crba_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/core/chained_region_bump_allocator_core.sv @@
`default_nettype none
// Sequence: a release goes straight to the result stage. An allocate reads the fill
// table and checks the fit for each region scanned from the current region; if nothing
// fits, a new-region evaluation follows (a refusal ends there), else a miss-count pass
// runs when the current region is not the last one, and a new region opens. One item at
// a time, and the result stage waits while the output is held; the single-port fill table
// read sets the scan pace. Reset leaves one open region with the default first header; no clearing pass.
// ----------------------------------------------------------------------------
// chained_region_bump_allocator_core
// Top level: bump allocation over a chain of fixed-size regions.
// ----------------------------------------------------------------------------
module chained_region_bump_allocator_core
  import crba_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = CRBA_MAX_REGIONS,
  parameter int unsigned MISS_LIMIT  = CRBA_MISS_LIMIT
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  crba_chan_if.sink    req_i,
  crba_chan_if.sink    cfg_i,
  crba_chan_if.source  rsp_o
);

  crba_cmd_t cmd;
  crba_sts_t sts;
  crba_rsp_t rsp_payload;
  logic      req_ready;
  logic      rsp_valid;

  crba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.payload.func),
    .req_ready_o (req_ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  crba_datapath #(
    .MAX_REGIONS (MAX_REGIONS),
    .MISS_LIMIT  (MISS_LIMIT)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .req_i    (req_i.payload),
    .cfg_we_i (cfg_i.valid),
    .cfg_i    (cfg_i.payload),
    .rsp_o    (rsp_payload)
  );

  assign req_i.ready   = req_ready;
  assign cfg_i.ready   = 1'b1;
  assign rsp_o.valid   = rsp_valid;
  assign rsp_o.payload = rsp_payload;

`ifndef SYNTHESIS
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("controller issued overlapping commands");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while previous one still in flight");

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.payload.status != ST_GRANTED)) |->
      ((rsp_o.payload.region_index == '0) && (rsp_o.payload.byte_offset == '0)))
    else $error("non-grant result carries region or offset");
`endif

endmodule
`default_nettype wire

@@ rtl/core/crba_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crba_ctrl
// Sequencer: scans regions, runs the miss-count pass and hands out results.
// ----------------------------------------------------------------------------
module crba_ctrl
  import crba_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        req_valid_i,
  input  wire        req_func_i,
  output logic       req_ready_o,
  input  wire        rsp_ready_i,
  output logic       rsp_valid_o,
  input  wire crba_sts_t sts_i,
  output crba_cmd_t  cmd_o
);

  crba_state_e state_q, state_d;
  logic        rsp_valid_q, rsp_valid_d;
  logic        req_beat;
  logic        out_free;

  assign req_beat = req_valid_i && (state_q == S_IDLE);
  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_beat) state_d = req_func_i ? S_RESP : S_READ;
      end
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        if (sts_i.fit)            state_d = S_RESP;
        else if (sts_i.scan_more) state_d = S_READ;
        else                      state_d = S_NEW;
      end
      S_NEW: begin
        if (sts_i.too_big || sts_i.chain_full) state_d = S_RESP;
        else if (sts_i.cur_has_next)           state_d = S_MISS_RD;
        else                                   state_d = S_OPEN;
      end
      S_MISS_RD: state_d = S_MISS_WR;
      S_MISS_WR: state_d = sts_i.miss_more ? S_MISS_RD : S_OPEN;
      S_OPEN:    state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o       = 1'b1;
        cmd_o.start       = req_beat && !req_func_i;
        cmd_o.release_all = req_beat && req_func_i;
      end
      S_READ:    cmd_o.rd_fill     = 1'b1;
      S_CHECK:   cmd_o.check       = 1'b1;
      S_NEW:     cmd_o.new_eval    = 1'b1;
      S_MISS_RD: cmd_o.miss_rd     = 1'b1;
      S_MISS_WR: cmd_o.miss_wr     = 1'b1;
      S_OPEN:    cmd_o.open_region = 1'b1;
      S_RESP:    cmd_o.load_out    = out_free;
      default: ;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.load_out)   rsp_valid_d = 1'b1;
    else if (rsp_ready_i) rsp_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule
`default_nettype wire

@@ rtl/core/crba_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crba_datapath
// Region tables, configuration registers, fit arithmetic and result registers.
// ----------------------------------------------------------------------------
module crba_datapath
  import crba_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = CRBA_MAX_REGIONS,
  parameter int unsigned MISS_LIMIT  = CRBA_MISS_LIMIT
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire crba_cmd_t cmd_i,
  output crba_sts_t  sts_o,
  input  wire crba_req_t req_i,
  input  wire        cfg_we_i,
  input  wire crba_cfg_t cfg_i,
  output crba_rsp_t  rsp_o
);

  localparam int unsigned RW = $clog2(MAX_REGIONS);
  localparam int unsigned OW = RW + 1;

  // configuration
  logic [SIZE_W-1:0] region_bytes_q;
  logic [HDR_W-1:0]  first_hdr_q;
  logic [HDR_W-1:0]  later_hdr_q;

  // chain state; entry 0 of the fill table lives in a register
  logic [SIZE_W-1:0]      fill0_q;
  logic [SIZE_W-1:0]      fill_mem [MAX_REGIONS];
  logic [SIZE_W-1:0]      fill_rd_q;
  logic [MISS_W-1:0]      miss_mem [MAX_REGIONS];
  logic [MISS_W-1:0]      miss_rd_q;
  logic [MAX_REGIONS-1:0] miss_vld_q;
  logic [OW-1:0]          open_q;
  logic [RW-1:0]          cur_q;

  // per-request working registers
  logic [RW-1:0]       r_q;
  logic [SIZE_W-1:0]   size_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [RW-1:0]       res_idx_q;
  logic [SIZE_W-1:0]   res_off_q;
  crba_rsp_t           out_q;

  logic [SIZE_W-1:0] fill_cur;
  logic [SIZE_W:0]   room;
  logic [SIZE_W:0]   fill_sum;
  logic [SIZE_W-1:0] fill_new;
  logic              fit;
  logic [OW-1:0]     r_next;
  logic [SIZE_W-1:0] later_ext;
  logic [SIZE_W-1:0] fresh_room;
  logic [SIZE_W:0]   new_sum;
  logic [RW-1:0]     new_idx;
  logic [MISS_W-1:0] miss_old;
  logic [MISS_W-1:0] miss_new;
  logic              fill_we;
  logic [RW-1:0]     fill_waddr;
  logic [SIZE_W-1:0] fill_wdata;

  assign fill_cur = (r_q == '0) ? fill0_q : fill_rd_q;
  // a region filled past its size (after a size change) underflows here and never fits
  assign room     = {1'b0, region_bytes_q} - {1'b0, fill_cur};
  assign fit      = !room[SIZE_W] && (room[SIZE_W-1:0] >= size_q);
  assign fill_sum = {1'b0, fill_cur} + {1'b0, size_q};
  assign fill_new = fill_sum[SIZE_W-1:0];
  assign r_next   = {1'b0, r_q} + OW'(1);

  assign later_ext  = {{(SIZE_W-HDR_W){1'b0}}, later_hdr_q};
  assign fresh_room = (region_bytes_q > later_ext) ? (region_bytes_q - later_ext) : '0;
  assign new_sum    = {1'b0, later_ext} + {1'b0, size_q};
  assign new_idx    = open_q[RW-1:0];

  assign miss_old = miss_vld_q[r_q] ? miss_rd_q : '0;
  assign miss_new = (miss_old == MISS_MAX) ? miss_old : (miss_old + MISS_W'(1));

  assign sts_o.fit          = fit;
  assign sts_o.scan_more    = r_next < open_q;
  assign sts_o.too_big      = size_q > fresh_room;
  assign sts_o.chain_full   = open_q >= OW'(MAX_REGIONS);
  assign sts_o.cur_has_next = ({1'b0, cur_q} + OW'(1)) < open_q;
  assign sts_o.miss_more    = ({1'b0, r_q} + OW'(2)) < open_q;

  assign fill_we    = (cmd_i.check && fit && (r_q != '0)) || cmd_i.open_region;
  assign fill_waddr = cmd_i.open_region ? new_idx : r_q;
  assign fill_wdata = cmd_i.open_region ? new_sum[SIZE_W-1:0] : fill_new;

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (cmd_i.rd_fill) fill_rd_q <= fill_mem[r_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.miss_wr) miss_mem[r_q] <= miss_new;
    if (cmd_i.miss_rd) miss_rd_q <= miss_mem[r_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_bytes_q <= REGION_BYTES_RST;
      first_hdr_q    <= FIRST_HDR_RST;
      later_hdr_q    <= LATER_HDR_RST;
      fill0_q        <= {{(SIZE_W-HDR_W){1'b0}}, FIRST_HDR_RST};
      open_q         <= OW'(1);
      cur_q          <= '0;
      miss_vld_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (crba_reg_e'(cfg_i.index))
          REG_REGION_BYTES: region_bytes_q <= cfg_i.data;
          REG_FIRST_HDR:    first_hdr_q    <= cfg_i.data[HDR_W-1:0];
          REG_LATER_HDR:    later_hdr_q    <= cfg_i.data[HDR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.release_all) begin
        fill0_q    <= {{(SIZE_W-HDR_W){1'b0}}, first_hdr_q};
        open_q     <= OW'(1);
        cur_q      <= '0;
        miss_vld_q <= '0;
      end
      if (cmd_i.check && fit && (r_q == '0)) fill0_q <= fill_new;
      if (cmd_i.miss_wr) begin
        miss_vld_q[r_q] <= 1'b1;
        // a region that kept missing is skipped by later scans
        if (miss_old > MISS_W'(MISS_LIMIT)) cur_q <= r_next[RW-1:0];
      end
      if (cmd_i.open_region) begin
        miss_vld_q[new_idx] <= 1'b0;
        open_q              <= open_q + OW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      size_q <= req_i.request_size;
      r_q    <= cur_q;
    end
    if (cmd_i.check && !fit) r_q <= r_next[RW-1:0];
    if (cmd_i.new_eval)      r_q <= cur_q;
    if (cmd_i.miss_wr)       r_q <= r_next[RW-1:0];

    if (cmd_i.release_all) begin
      res_status_q <= ST_RELEASED;
      res_idx_q    <= '0;
      res_off_q    <= '0;
    end
    if (cmd_i.check && fit) begin
      res_status_q <= ST_GRANTED;
      res_idx_q    <= r_q;
      res_off_q    <= fill_cur;
    end
    if (cmd_i.new_eval) begin
      res_status_q <= sts_o.too_big ? ST_TOO_BIG : ST_NO_REGION;
      res_idx_q    <= '0;
      res_off_q    <= '0;
    end
    if (cmd_i.open_region) begin
      res_status_q <= ST_GRANTED;
      res_idx_q    <= new_idx;
      res_off_q    <= later_ext;
    end

    if (cmd_i.load_out) begin
      out_q.status       <= res_status_q;
      out_q.region_index <= IDX_W'(res_idx_q);
      out_q.byte_offset  <= res_off_q;
    end
  end

  assign rsp_o = out_q;

endmodule
`default_nettype wire
